// ===== sv/lfmd_pkg.sv =====
// Package of shared constants and types for the length-framed message deframer.
`default_nettype none

package lfmd_pkg;

    // Sizes of the frame store and of a frame.
    localparam int STORE_DEPTH = 64;
    localparam int MAX_RESULTS = 64;
    localparam int HEAD_LEN    = 2;
    localparam int FOOT_LEN    = 1;
    localparam int MIN_LEN     = 4;
    localparam int LEN_CAP     = MAX_RESULTS + HEAD_LEN + FOOT_LEN;
    localparam int LEN_LIMIT   = (STORE_DEPTH < LEN_CAP) ? STORE_DEPTH : LEN_CAP;

    // Widths.
    localparam int BYTE_W    = 8;
    localparam int MAXL_W    = 7;
    localparam int PTR_W     = $clog2(STORE_DEPTH);
    localparam int CNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W     = $clog2(MAX_RESULTS);
    localparam int CMP_W     = (CNT_W > BYTE_W) ? CNT_W : BYTE_W;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_MARKER  = 2'd0,
        REG_END_MARKER    = 2'd1,
        REG_MAX_FRAME_LEN = 2'd2
    } cfg_reg_t;

    // Configuration as the sequencer sees it; max_len is already limited.
    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] end_marker;
        logic [BYTE_W-1:0] max_len;
    } cfg_t;

    // Request to the frame store.
    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_addr;
    } mem_req_t;

    // One payload byte handed to the output register.
    typedef struct packed {
        logic              load;
        logic [BYTE_W-1:0] data;
        logic              last;
    } emit_t;

endpackage

`default_nettype wire

// ===== sv/lfmd_store.sv =====
// Frame store: circular byte memory with one write port and a registered read port.
`default_nettype none

module lfmd_store
    import lfmd_pkg::*;
(
    input  wire logic              clk,
    input  wire mem_req_t          mem_req,
    output logic [BYTE_W-1:0]      rd_data
);

    logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            store_mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        // The read data holds until the next read is issued.
        if (mem_req.rd_en)
        begin
            rd_data_reg <= store_mem[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/lfmd_ctrl.sv =====
// Sequencer that appends bytes, scans for frames and streams out validated payloads.
`default_nettype none

module lfmd_ctrl
    import lfmd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire cfg_t              cfg,
    input  wire logic              out_free,
    input  wire logic [BYTE_W-1:0] rd_data,
    output mem_req_t               mem_req,
    output emit_t                  emit,
    output logic                   idle
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_START,
        ST_LEN,
        ST_END,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [BYTE_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               last_byte;

    // Adds an offset below the store depth to a pointer, wrapping round the store.
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                                 input logic [PTR_W-1:0] off);
        logic [PTR_W:0] sum;
        begin
            sum = {1'b0, ptr} + {1'b0, off};
            if (sum >= (PTR_W+1)'(STORE_DEPTH))
            begin
                sum = sum - (PTR_W+1)'(STORE_DEPTH);
            end
            return sum[PTR_W-1:0];
        end
    endfunction

    assign last_byte = (BYTE_W'(idx_reg) == len_reg - BYTE_W'(HEAD_LEN + FOOT_LEN + 1));
    assign idle      = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        mem_req    = '0;
        emit       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    // A byte that finds the store full is dropped.
                    if (count_reg < CNT_W'(STORE_DEPTH))
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = ptr_add(head_reg, PTR_W'(count_reg));
                        mem_req.wr_data = rx_byte;
                        count_next      = count_reg + 1'b1;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = head_reg;
                    state_next      = ST_START;
                end
            end
            ST_START:
            begin
                if (rd_data == cfg.start_marker)
                begin
                    if (count_reg < CNT_W'(HEAD_LEN))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ptr_add(head_reg, PTR_W'(1));
                        state_next      = ST_LEN;
                    end
                end
                else
                begin
                    head_next  = ptr_add(head_reg, PTR_W'(1));
                    count_next = count_reg - 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_LEN:
            begin
                len_next = rd_data;
                if (rd_data < BYTE_W'(MIN_LEN) || rd_data > cfg.max_len)
                begin
                    head_next  = ptr_add(head_reg, PTR_W'(1));
                    count_next = count_reg - 1'b1;
                    state_next = ST_SCAN;
                end
                else if (CMP_W'(count_reg) < CMP_W'(rd_data))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_add(head_reg, PTR_W'(rd_data - 1'b1));
                    state_next      = ST_END;
                end
            end
            ST_END:
            begin
                if (rd_data == cfg.end_marker)
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    head_next  = ptr_add(head_reg, PTR_W'(1));
                    count_next = count_reg - 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ptr_add(head_reg,
                                          PTR_W'(BYTE_W'(idx_reg) + BYTE_W'(HEAD_LEN)));
                state_next      = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (out_free)
                begin
                    emit.load = 1'b1;
                    emit.data = rd_data;
                    emit.last = last_byte;
                    if (last_byte)
                    begin
                        // Remove the whole frame from the store.
                        if (CMP_W'(count_reg) == CMP_W'(len_reg))
                        begin
                            count_next = '0;
                            head_next  = '0;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(len_reg);
                            head_next  = ptr_add(head_reg, PTR_W'(len_reg));
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/length_framed_message_deframer_top.sv =====
// Top level of the length-framed message deframer: configuration, store, sequencer, output.
//
// Received bytes enter one per transfer on the input channel (in_valid, in_ready, rx_byte).
// The block looks for frames laid out as start marker, total length byte, payload and end
// marker, and sends each payload byte of a valid frame as one transfer on the output channel
// (out_valid, out_ready, payload_byte, frame_last), with frame_last set on the final byte.
// Bytes ahead of a start marker are discarded; a bad length or a missing end marker discards
// the start byte and the held bytes are scanned again for the next start marker.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets the start
// marker, the end marker and the largest accepted frame length; it is always ready. The user
// must write it only while the block is idle; the block itself does not enforce this.
// Operation: one shared sequencer and a one-write, one-read store handle one byte at a time.
// Each byte passes through its transfer, then a read and a test of the front byte. Every
// further byte discarded by the scan takes another read and test, the length check and the
// end-marker check a read each, and every payload byte a read and an output load that waits
// for a free output register. At most one frame leaves per input byte.
// The last payload byte of a frame waits in the output register, so the next input byte is
// taken while it is still held. When the receiver stalls, the sequencer waits with the next
// payload byte and in_ready stays low until the last byte has entered the output register.
// Reset empties the store and loads the default configuration; no clearing pass is needed.
`default_nettype none

module length_framed_message_deframer_top
    import lfmd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [BYTE_W-1:0]    rx_byte,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [BYTE_W-1:0]         payload_byte,
    output logic                      frame_last,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data
);

    logic [BYTE_W-1:0] start_marker_reg;
    logic [BYTE_W-1:0] end_marker_reg;
    logic [MAXL_W-1:0] max_frame_len_reg;
    logic [BYTE_W-1:0] max_len_lim;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] payload_reg;
    logic              last_reg;

    cfg_t              cfg;
    mem_req_t          mem_req;
    emit_t             emit;
    logic [BYTE_W-1:0] rd_data;
    logic              idle;
    logic              in_fire;
    logic              out_free;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg  <= '0;
            end_marker_reg    <= '0;
            max_frame_len_reg <= MAXL_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_MARKER:  start_marker_reg  <= cfg_data;
                REG_END_MARKER:    end_marker_reg    <= cfg_data;
                REG_MAX_FRAME_LEN: max_frame_len_reg <= cfg_data[MAXL_W-1:0];
                default:           ;
            endcase
        end
    end

    // The accepted length never exceeds the store, nor a payload of the largest result count.
    assign max_len_lim = ({1'b0, max_frame_len_reg} > BYTE_W'(LEN_LIMIT))
                         ? BYTE_W'(LEN_LIMIT) : {1'b0, max_frame_len_reg};

    assign cfg.start_marker = start_marker_reg;
    assign cfg.end_marker   = end_marker_reg;
    assign cfg.max_len      = max_len_lim;

    assign in_ready = idle;
    assign in_fire  = in_valid && in_ready;

    // The output register is free when empty or when its byte is taken this cycle.
    assign out_free = !out_valid_reg || out_ready;

    lfmd_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    lfmd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .rx_byte  (rx_byte),
        .cfg      (cfg),
        .out_free (out_free),
        .rd_data  (rd_data),
        .mem_req  (mem_req),
        .emit     (emit),
        .idle     (idle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            payload_reg <= emit.data;
            last_reg    <= emit.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = payload_reg;
    assign frame_last   = last_reg;

endmodule

`default_nettype wire

// ===== sv/lfmd_checker.sv =====
// Port-level checker for the length-framed message deframer, bound to the top level.
`default_nettype none

module lfmd_checker
    import lfmd_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [BYTE_W-1:0] payload_byte,
    input wire logic              frame_last
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(frame_last))
        else $error("stalled output transfer changed");

    // Each accepted byte moves the sequencer out of idle, which drops in_ready.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready straight after an accepted byte");

    // A new result only appears while the block is working on a byte.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while the block was idle");

endmodule

bind length_framed_message_deframer_top lfmd_checker u_lfmd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .frame_last   (frame_last)
);

`default_nettype wire
